@@ hw/rtl/bfta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_pkg
// Shared widths, defaults, sequencer states, memory control and the clamped-add helper of the task assigner.
// ----------------------------------------------------------------------------
package bfta_pkg;

  // field widths
  localparam int unsigned TaskW = 16;
  localparam int unsigned LoadW = 32;
  localparam int unsigned CfgW  = 5;
  localparam int unsigned ProcW = 4;

  // defaults
  localparam int unsigned MaxProcsDef = 16;
  localparam logic [CfgW-1:0] NumProcsRst = CfgW'(16);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MIN,
    S_DEC,
    S_FIT,
    S_WRITE
  } state_e;

  // control from the sequencer to the load memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } mem_ctrl_t;

  // load plus task, clamped at the all-ones load
  function automatic logic [LoadW-1:0] sat_add(input logic [LoadW-1:0] load,
                                               input logic [TaskW-1:0] tsk);
    logic [LoadW:0] sum;
    sum = {1'b0, load} + (LoadW+1)'(tsk);
    return sum[LoadW] ? {LoadW{1'b1}} : sum[LoadW-1:0];
  endfunction

endpackage

@@ hw/rtl/bfta_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_if
// Valid/ready channels of the task assigner: task in, result out, config.
// ----------------------------------------------------------------------------

// task beat channel
interface bfta_in_if;
  logic                      valid;
  logic                      ready;
  logic [bfta_pkg::TaskW-1:0] task_time;
  logic                      new_job;
  logic                      last_task;

  modport source (output valid, task_time, new_job, last_task, input ready);
  modport sink   (input valid, task_time, new_job, last_task, output ready);
endinterface

// result beat channel
interface bfta_out_if;
  logic                      valid;
  logic                      ready;
  logic [bfta_pkg::ProcW-1:0] chosen_proc;
  logic [bfta_pkg::LoadW-1:0] chosen_load;
  logic [bfta_pkg::LoadW-1:0] makespan;
  logic                      job_done;

  modport source (output valid, chosen_proc, chosen_load, makespan, job_done,
                  input ready);
  modport sink   (input valid, chosen_proc, chosen_load, makespan, job_done,
                  output ready);
endinterface

// processor count write channel
interface bfta_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [bfta_pkg::CfgW-1:0] num_procs;

  modport source (output valid, num_procs, input ready);
  modport sink   (input valid, num_procs, output ready);
endinterface

@@ hw/rtl/bfta_load_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_load_mem
// Processor load memory: one write and one registered read port, with an
// entry valid bit so that reset and a new job read as zero load.
// ----------------------------------------------------------------------------
module bfta_load_mem #(
  parameter int unsigned MAX_PROCS = bfta_pkg::MaxProcsDef,
  parameter int unsigned IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfta_pkg::mem_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]           rd_addr_i,
  input  logic [IDX_W-1:0]           wr_addr_i,
  input  logic [bfta_pkg::LoadW-1:0] wr_data_i,
  output logic [bfta_pkg::LoadW-1:0] rd_data_o
);

  logic [bfta_pkg::LoadW-1:0] mem [MAX_PROCS];
  logic [MAX_PROCS-1:0]       vld_q;
  logic [bfta_pkg::LoadW-1:0] rd_data_q;
  logic                       rd_vld_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // entry valid bits, cleared by reset and at job start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_all) begin
        vld_q <= '0;
      end else if (ctrl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ hw/rtl/best_fit_task_assigner.sv @@
`timescale 1ns / 1ps
// Tasks: one task at a time; a new task beat is taken only in the idle state, once
// the previous result is in the output register. Each task makes one or two ordered
// passes over the active entries of the load memory (the second only when the least
// load plus the task stays below the makespan), one load read per cycle through its single read port.
// Reset: all loads and the makespan read as zero, processor count is 16.
// ----------------------------------------------------------------------------
// best_fit_task_assigner
// Greedy least-loaded task placement with a best-fit pass below the makespan.
// ----------------------------------------------------------------------------
module best_fit_task_assigner #(
  parameter int unsigned MAX_PROCS = bfta_pkg::MaxProcsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bfta_in_if.sink    in_i,
  bfta_out_if.source out_o,
  bfta_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);

  bfta_pkg::state_e state_q, state_d;

  logic [bfta_pkg::CfgW-1:0]  num_q;
  logic [CntW-1:0]            act_n;
  logic [CntW-1:0]            issue_cnt_q;
  logic                       proc_en_q;
  logic [IdxW-1:0]            proc_idx_q;
  logic                       scan_done;
  logic                       scan_st;
  logic                       issue;

  logic [bfta_pkg::TaskW-1:0] task_q;
  logic                       last_q;
  logic [bfta_pkg::LoadW-1:0] max_q;
  logic [bfta_pkg::LoadW-1:0] min_q;
  logic [IdxW-1:0]            min_idx_q;
  logic [bfta_pkg::LoadW-1:0] load0_q;
  logic [bfta_pkg::LoadW-1:0] trk_q;
  logic [IdxW-1:0]            sel_idx_q;
  logic [bfta_pkg::LoadW-1:0] sel_sum_q;

  logic [bfta_pkg::LoadW-1:0] rd_load;
  logic [bfta_pkg::LoadW-1:0] rd_sum;
  logic [bfta_pkg::LoadW-1:0] min_sum;
  logic                       fit;

  logic                       out_vld_q;
  logic [bfta_pkg::ProcW-1:0] out_proc_q;
  logic [bfta_pkg::LoadW-1:0] out_load_q;
  logic [bfta_pkg::LoadW-1:0] out_span_q;
  logic                       out_done_q;

  logic                       in_rdy;
  logic                       in_acc;
  logic                       out_load;
  logic                       out_free;
  bfta_pkg::mem_ctrl_t        mem_ctrl;

  // active processor count, clamped to 1..MAX_PROCS
  always_comb begin
    if (num_q == '0) begin
      act_n = CntW'(1);
    end else if (32'(num_q) > 32'(MAX_PROCS)) begin
      act_n = CntW'(MAX_PROCS);
    end else begin
      act_n = CntW'(num_q);
    end
  end

  // config register, always ready
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= bfta_pkg::NumProcsRst;
    end else if (cfg_i.valid) begin
      num_q <= cfg_i.num_procs;
    end
  end

  // scan bookkeeping
  assign scan_st   = (state_q == bfta_pkg::S_MIN) || (state_q == bfta_pkg::S_FIT);
  assign issue     = scan_st && (issue_cnt_q < act_n);
  assign scan_done = proc_en_q && (CntW'(proc_idx_q) == (act_n - CntW'(1)));
  assign in_acc    = in_i.valid && in_rdy;
  assign out_free  = !out_vld_q || out_o.ready;

  // per-read arithmetic
  assign rd_sum  = bfta_pkg::sat_add(rd_load, task_q);
  assign min_sum = bfta_pkg::sat_add(min_q, task_q);
  assign fit     = (rd_sum <= max_q) && (trk_q <= rd_load);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfta_pkg::S_IDLE: begin
        if (in_i.valid) state_d = bfta_pkg::S_MIN;
      end
      bfta_pkg::S_MIN: begin
        if (scan_done) state_d = bfta_pkg::S_DEC;
      end
      bfta_pkg::S_DEC: begin
        state_d = (min_sum >= max_q) ? bfta_pkg::S_WRITE : bfta_pkg::S_FIT;
      end
      bfta_pkg::S_FIT: begin
        if (scan_done) state_d = bfta_pkg::S_WRITE;
      end
      bfta_pkg::S_WRITE: begin
        if (out_free) state_d = bfta_pkg::S_IDLE;
      end
      default: state_d = bfta_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_rdy           = 1'b0;
    out_load         = 1'b0;
    mem_ctrl.rd_en   = 1'b0;
    mem_ctrl.wr_en   = 1'b0;
    mem_ctrl.clr_all = 1'b0;
    case (state_q)
      bfta_pkg::S_IDLE: begin
        in_rdy           = 1'b1;
        mem_ctrl.clr_all = in_i.valid && in_i.new_job;
      end
      bfta_pkg::S_MIN, bfta_pkg::S_FIT: begin
        mem_ctrl.rd_en = issue;
      end
      bfta_pkg::S_WRITE: begin
        out_load       = out_free;
        mem_ctrl.wr_en = out_free;
      end
      default: ;
    endcase
  end

  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfta_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // read issue counter and returning-data tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_cnt_q <= '0;
      proc_en_q   <= 1'b0;
      proc_idx_q  <= '0;
    end else begin
      proc_en_q  <= issue;
      proc_idx_q <= issue_cnt_q[IdxW-1:0];
      if (issue) begin
        issue_cnt_q <= issue_cnt_q + CntW'(1);
      end else if (!scan_st) begin
        issue_cnt_q <= '0;
      end
    end
  end

  // makespan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (in_acc && in_i.new_job) begin
      max_q <= '0;
    end else if ((state_q == bfta_pkg::S_DEC) && (min_sum >= max_q)) begin
      max_q <= min_sum;
    end
  end

  // scan datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      bfta_pkg::S_IDLE: begin
        if (in_acc) begin
          task_q <= in_i.task_time;
          last_q <= in_i.last_task;
        end
      end
      bfta_pkg::S_MIN: begin
        if (proc_en_q) begin
          if (proc_idx_q == '0) begin
            min_q     <= rd_load;
            min_idx_q <= '0;
            load0_q   <= rd_load;
          end else if (rd_load < min_q) begin
            min_q     <= rd_load;
            min_idx_q <= proc_idx_q;
          end
        end
      end
      bfta_pkg::S_DEC: begin
        sel_idx_q <= min_idx_q;
        sel_sum_q <= min_sum;
        trk_q     <= load0_q;
      end
      bfta_pkg::S_FIT: begin
        if (proc_en_q && fit) begin
          trk_q     <= rd_load;
          sel_idx_q <= proc_idx_q;
          sel_sum_q <= rd_sum;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_proc_q <= bfta_pkg::ProcW'(sel_idx_q);
      out_load_q <= sel_sum_q;
      out_span_q <= max_q;
      out_done_q <= last_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.chosen_proc = out_proc_q;
  assign out_o.chosen_load = out_load_q;
  assign out_o.makespan    = out_span_q;
  assign out_o.job_done    = out_done_q;

  // load memory
  bfta_load_mem #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IdxW)
  ) u_load_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .rd_addr_i (issue_cnt_q[IdxW-1:0]),
    .wr_addr_i (sel_idx_q),
    .wr_data_i (sel_sum_q),
    .rd_data_o (rd_load)
  );

endmodule

@@ hw/rtl/bfta_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_checker
// Port-level checks of the task assigner, bound to the top level.
// ----------------------------------------------------------------------------
module bfta_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [bfta_pkg::ProcW-1:0] chosen_proc_i,
  input logic [bfta_pkg::LoadW-1:0] chosen_load_i,
  input logic [bfta_pkg::LoadW-1:0] makespan_i
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(chosen_proc_i) && $stable(chosen_load_i) && $stable(makespan_i))
    else $error("result payload changed while stalled");

  // the chosen load never exceeds the makespan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> chosen_load_i <= makespan_i)
    else $error("chosen load above makespan");

  // one task in flight: busy right after a task beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("task accepted while previous one in progress");

endmodule

bind best_fit_task_assigner bfta_checker u_bfta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .chosen_proc_i (out_o.chosen_proc),
  .chosen_load_i (out_o.chosen_load),
  .makespan_i    (out_o.makespan)
);

@@ tb/best_fit_task_assigner_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_task_assigner_tb
// Self-checking bench for the greedy task assigner. A behavioral copy of the
// placement rule predicts processor, load and makespan for every task beat.
// The bench walks through processor count limits, idle processors, the
// best-fit pass, heavy loads, output back-pressure and random job streams
// with random gaps on both channels.
// ----------------------------------------------------------------------------
module best_fit_task_assigner_tb;

  localparam int unsigned NPROCS     = 16;
  localparam int unsigned SETTLE_CYC = 2 * NPROCS + 8;

  typedef struct packed {
    logic [bfta_pkg::ProcW-1:0] proc;
    logic [bfta_pkg::LoadW-1:0] load;
    logic [bfta_pkg::LoadW-1:0] span;
    logic                       done;
  } placement_t;

  logic clk_i;
  logic rst_ni;

  bfta_in_if  in_if ();
  bfta_out_if out_if ();
  bfta_cfg_if cfg_if ();

  best_fit_task_assigner #(
    .MAX_PROCS(NPROCS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // shadow copy of the assigner state
  logic [bfta_pkg::LoadW-1:0] shadow_load [NPROCS];
  logic [bfta_pkg::LoadW-1:0] shadow_span;
  logic [bfta_pkg::CfgW-1:0]  shadow_nprocs;

  placement_t pending_placements[$];
  int unsigned err_cnt;
  bit steady;
  int unsigned stall_request;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("best_fit_task_assigner_tb: errors");
    $finish;
  end

  function automatic bit idle_now();
    if (steady) return 1'b0;
    return $urandom_range(99) < 19;
  endfunction

  function automatic logic [bfta_pkg::LoadW-1:0] add_clamped(
    input logic [bfta_pkg::LoadW-1:0] load,
    input logic [bfta_pkg::TaskW-1:0] t
  );
    logic [63:0] s;
    s = 64'(load) + 64'(t);
    if (s > 64'hFFFF_FFFF) return {bfta_pkg::LoadW{1'b1}};
    return s[bfta_pkg::LoadW-1:0];
  endfunction

  // placement rule: least loaded first, best fit below the makespan
  function automatic placement_t place_task(input logic [bfta_pkg::TaskW-1:0] t,
                                            input logic nj, input logic lt);
    int unsigned n;
    int unsigned pick;
    logic [bfta_pkg::LoadW-1:0] lowest;
    logic [bfta_pkg::LoadW-1:0] tracked;
    logic [bfta_pkg::LoadW-1:0] fill;
    placement_t p;
    if (shadow_nprocs == 0) n = 1;
    else if (shadow_nprocs > NPROCS) n = NPROCS;
    else n = shadow_nprocs;
    if (nj) begin
      foreach (shadow_load[k]) shadow_load[k] = '0;
      shadow_span = '0;
    end
    pick   = 0;
    lowest = shadow_load[0];
    for (int k = 1; k < n; k++) begin
      if (shadow_load[k] < lowest) begin
        lowest = shadow_load[k];
        pick   = k;
      end
    end
    fill = add_clamped(shadow_load[pick], t);
    if (fill >= shadow_span) begin
      shadow_span       = fill;
      shadow_load[pick] = fill;
    end else begin
      // last processor that still fits and is at least the tracked load wins
      tracked = shadow_load[0];
      for (int k = 0; k < n; k++) begin
        if (add_clamped(shadow_load[k], t) <= shadow_span && tracked <= shadow_load[k]) begin
          tracked = shadow_load[k];
          pick    = k;
        end
      end
      shadow_load[pick] = add_clamped(shadow_load[pick], t);
    end
    p.proc = bfta_pkg::ProcW'(pick);
    p.load = shadow_load[pick];
    p.span = shadow_span;
    p.done = lt;
    return p;
  endfunction

  function automatic logic [bfta_pkg::TaskW-1:0] pick_runtime();
    case ($urandom_range(9))
      0:       return '0;
      1:       return {bfta_pkg::TaskW{1'b1}};
      2, 3, 4: return bfta_pkg::TaskW'($urandom_range(15));
      5, 6, 7: return bfta_pkg::TaskW'($urandom_range(999));
      default: return bfta_pkg::TaskW'($urandom);
    endcase
  endfunction

  function automatic logic [bfta_pkg::CfgW-1:0] pick_nprocs();
    case ($urandom_range(7))
      0:       return '0;
      1:       return bfta_pkg::CfgW'(1);
      2:       return bfta_pkg::CfgW'(NPROCS);
      3:       return bfta_pkg::CfgW'($urandom_range(31, NPROCS + 1));
      default: return bfta_pkg::CfgW'($urandom_range(NPROCS - 1, 2));
    endcase
  endfunction

  // one task beat, with random gaps ahead of it
  task automatic send_task(input logic [bfta_pkg::TaskW-1:0] t, input logic nj,
                           input logic lt);
    @(negedge clk_i);
    while (idle_now()) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.task_time = t;
    in_if.new_job   = nj;
    in_if.last_task = lt;
    do @(posedge clk_i); while (!in_if.ready);
    pending_placements.push_back(place_task(t, nj, lt));
  endtask

  // drop valid and wait until every result is back and the block is idle
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_placements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_nprocs(input logic [bfta_pkg::CfgW-1:0] v);
    @(negedge clk_i);
    cfg_if.valid     = 1'b1;
    cfg_if.num_procs = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    shadow_nprocs = v;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // result receiver: random stalls, plus long hold-offs on request
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = !idle_now();
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_placements.size() == 0) begin
        log_error($sformatf("unexpected result proc=%0d load=%0h span=%0h done=%0b",
                            out_if.chosen_proc, out_if.chosen_load, out_if.makespan,
                            out_if.job_done));
      end else begin
        want = pending_placements.pop_front();
        if (out_if.chosen_proc !== want.proc || out_if.chosen_load !== want.load ||
            out_if.makespan !== want.span || out_if.job_done !== want.done) begin
          log_error($sformatf({"mismatch exp proc=%0d load=%0h span=%0h done=%0b",
                               " got proc=%0d load=%0h span=%0h done=%0b"},
                              want.proc, want.load, want.span, want.done,
                              out_if.chosen_proc, out_if.chosen_load, out_if.makespan,
                              out_if.job_done));
        end
      end
    end
  end

  // state straight out of reset, default processor count
  task automatic test_reset_state();
    send_task('0, 1'b0, 1'b0);
    send_task({bfta_pkg::TaskW{1'b1}}, 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(7), 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(7), 1'b0, 1'b1);
    settle();
  endtask

  // zero acts as one processor, anything above the maximum as the maximum
  task automatic test_proc_limits();
    set_nprocs('0);
    send_task(bfta_pkg::TaskW'(5), 1'b1, 1'b0);
    send_task(bfta_pkg::TaskW'(3), 1'b0, 1'b1);
    settle();
    set_nprocs({bfta_pkg::CfgW{1'b1}});
    send_task(bfta_pkg::TaskW'(9), 1'b1, 1'b0);
    send_task(bfta_pkg::TaskW'(2), 1'b0, 1'b0);
    settle();
    set_nprocs(bfta_pkg::CfgW'(NPROCS + 1));
    send_task(bfta_pkg::TaskW'(4), 1'b1, 1'b0);
    send_task(bfta_pkg::TaskW'(4), 1'b0, 1'b1);
    settle();
  endtask

  // loads of switched-off processors are kept until they come back
  task automatic test_idle_procs();
    set_nprocs(bfta_pkg::CfgW'(4));
    send_task(bfta_pkg::TaskW'(1), 1'b1, 1'b0);
    send_task(bfta_pkg::TaskW'(2), 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(3), 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(4), 1'b0, 1'b0);
    settle();
    set_nprocs(bfta_pkg::CfgW'(2));
    send_task(bfta_pkg::TaskW'(6), 1'b0, 1'b0);
    settle();
    set_nprocs(bfta_pkg::CfgW'(4));
    send_task(bfta_pkg::TaskW'(1), 1'b0, 1'b1);
    settle();
  endtask

  // best-fit pass picks a loaded processor below the makespan
  task automatic test_best_fit();
    set_nprocs(bfta_pkg::CfgW'(3));
    send_task(bfta_pkg::TaskW'(1), 1'b1, 1'b0);
    send_task(bfta_pkg::TaskW'(10), 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(2), 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(5), 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(1), 1'b0, 1'b0);
    send_task(bfta_pkg::TaskW'(0), 1'b0, 1'b1);
    settle();
  endtask

  // stack full-size tasks on one processor back to back, then let others join
  task automatic test_heavy_load();
    steady = 1'b1;
    set_nprocs(bfta_pkg::CfgW'(1));
    send_task({bfta_pkg::TaskW{1'b1}}, 1'b1, 1'b0);
    for (int k = 1; k < 64; k++) send_task({bfta_pkg::TaskW{1'b1}}, 1'b0, 1'b0);
    settle();
    steady = 1'b0;
    set_nprocs(bfta_pkg::CfgW'(2));
    send_task(bfta_pkg::TaskW'(3), 1'b0, 1'b0);
    send_task({bfta_pkg::TaskW{1'b1}}, 1'b0, 1'b0);
    settle();
    set_nprocs(bfta_pkg::CfgW'(3));
    send_task('0, 1'b0, 1'b1);
    send_task(bfta_pkg::TaskW'(8), 1'b1, 1'b0);
    settle();
  endtask

  // receiver holds off long enough for the input to stall
  task automatic test_backpressure();
    set_nprocs(bfta_pkg::CfgW'(8));
    stall_request = 400;
    send_task(pick_runtime(), 1'b1, 1'b0);
    for (int k = 0; k < 30; k++) send_task(pick_runtime(), 1'b0, k == 29);
    settle();
  endtask

  // random job streams, mostly well formed, some broken and some noise
  task automatic test_random_jobs();
    int unsigned sent;
    int unsigned job_len;
    int unsigned kind;
    for (int phase = 0; phase < 8; phase++) begin
      set_nprocs(pick_nprocs());
      sent = 0;
      while (sent < 150) begin
        kind    = $urandom_range(9);
        job_len = $urandom_range(30, 1);
        for (int k = 0; k < job_len; k++) begin
          if (kind < 8)
            send_task(pick_runtime(), k == 0, k == job_len - 1);
          else if (kind == 8)
            send_task(pick_runtime(), 1'b0, $urandom_range(3) == 0);
          else
            send_task(pick_runtime(), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        sent += job_len;
      end
      settle();
    end
  endtask

  // main sequence
  initial begin
    err_cnt         = 0;
    steady          = 1'b0;
    stall_request   = 0;
    shadow_nprocs   = bfta_pkg::NumProcsRst;
    shadow_span     = '0;
    foreach (shadow_load[k]) shadow_load[k] = '0;
    in_if.valid     = 1'b0;
    in_if.task_time = '0;
    in_if.new_job   = 1'b0;
    in_if.last_task = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.num_procs = '0;
    rst_ni          = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_proc_limits();
    test_idle_procs();
    test_best_fit();
    test_heavy_load();
    test_backpressure();
    test_random_jobs();

    if (err_cnt == 0) begin
      $display("best_fit_task_assigner_tb: clean");
    end else begin
      $display("best_fit_task_assigner_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bfta_pkg.sv
hw/rtl/bfta_if.sv
hw/rtl/bfta_load_mem.sv
hw/rtl/best_fit_task_assigner.sv
hw/rtl/bfta_checker.sv
tb/best_fit_task_assigner_tb.sv
